>>> rtl/psue_pkg.sv
// shared types, constants and small lookup functions for the particle swarm update engine
// no dependencies; used by particle_swarm_update_engine_core
package psue_pkg;

  // sequencer states, one-hot
  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_RD   = 15'b000000000000010,
    S_LD   = 15'b000000000000100,
    S_MLD  = 15'b000000000001000,
    S_MRUN = 15'b000000000010000,
    S_MWB  = 15'b000000000100000,
    S_VEL  = 15'b000000001000000,
    S_SQLD = 15'b000000010000000,
    S_SQ   = 15'b000000100000000,
    S_MOD  = 15'b000001000000000,
    S_FOLD = 15'b000010000000000,
    S_COR  = 15'b000100000000000,
    S_FIN  = 15'b001000000000000,
    S_PB   = 15'b010000000000000,
    S_OUT  = 15'b100000000000000
  } state_t;

  // multiplier operation codes
  typedef enum logic [2:0] {
    OP_INERTIA = 3'd0,
    OP_COG_G   = 3'd1,
    OP_COG_T   = 3'd2,
    OP_SOC_G   = 3'd3,
    OP_SOC_T   = 3'd4,
    OP_PHI_G   = 3'd5,
    OP_PHI_T   = 3'd6,
    OP_FIT     = 3'd7
  } mul_op_t;

  // configuration register indexes
  localparam logic [1:0] CFG_INERTIA   = 2'd0;
  localparam logic [1:0] CFG_COGNITIVE = 2'd1;
  localparam logic [1:0] CFG_SOCIAL    = 2'd2;
  localparam logic [1:0] CFG_EXTRA     = 2'd3;

  localparam logic [15:0] INERTIA_RST   = 16'd2048;
  localparam logic [15:0] COGNITIVE_RST = 16'd8192;
  localparam logic [15:0] SOCIAL_RST    = 16'd8192;
  localparam logic [15:0] EXTRA_RST     = 16'd2048;

  localparam logic signed [47:0] BEST_RST  = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] FIT_BIAS2 = 48'sd54916926;
  localparam logic [25:0]        TWO_PI_Q  = 26'd411775;
  localparam logic signed [20:0] PI_Q      = 21'sd205887;
  localparam logic signed [20:0] TWO_PI_S  = 21'sd411775;
  localparam logic signed [20:0] HALF_PI_Q = 21'sd102944;
  localparam logic signed [19:0] CORDIC_K  = 20'sd39797;
  localparam int                 MUL_BITS  = 18;
  localparam int                 CORDIC_N  = 24;

  // cordic arctangent steps, Q16.16
  function automatic logic [16:0] atan_q(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:  v = 17'd51472;
      5'd1:  v = 17'd30386;
      5'd2:  v = 17'd16055;
      5'd3:  v = 17'd8150;
      5'd4:  v = 17'd4091;
      5'd5:  v = 17'd2047;
      5'd6:  v = 17'd1024;
      5'd7:  v = 17'd512;
      5'd8:  v = 17'd256;
      5'd9:  v = 17'd128;
      5'd10: v = 17'd64;
      5'd11: v = 17'd32;
      5'd12: v = 17'd16;
      5'd13: v = 17'd8;
      5'd14: v = 17'd4;
      5'd15: v = 17'd2;
      5'd16: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // clamp a 40-bit signed value to 32 bits signed
  function automatic logic [31:0] sat40(input logic signed [39:0] v);
    logic [31:0] r;
    if (v > 40'sh00_7FFF_FFFF) r = 32'h7FFF_FFFF;
    else if (v < -40'sh00_8000_0000) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> rtl/particle_swarm_update_engine_core.sv
// particle swarm update engine: particle table, velocity update, schwefel scoring
// depends on psue_pkg (states, op codes, constants, arctangent table)
//
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall   | func, index, start position, random factors
// out     | output    | out_valid / out_stall | fitness, improve flags, global best
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data (gains, Q4.12)
//
// one item at a time; from acceptance to the next acceptance the time of a load or
// an update is set by the shared shift-add multiplier (18 add steps plus load and
// writeback per product), the 25-step root, the 7-step modulo and the 24-step
// cordic per dimension, and by out_stall while a result waits
// synchronous active-low reset sets control, gains and global best to their defaults only
// the result register holds under out_stall while the next item is taken

module particle_swarm_update_engine_core #(
  parameter int PARTICLE_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [4:0]  in_particle_index,
  input  logic [31:0] in_load_pos_x,
  input  logic [31:0] in_load_pos_y,
  input  logic [15:0] in_rand_cog_x,
  input  logic [15:0] in_rand_soc_x,
  input  logic [15:0] in_rand_phi_x,
  input  logic [15:0] in_rand_cog_y,
  input  logic [15:0] in_rand_soc_y,
  input  logic [15:0] in_rand_phi_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_particle_fitness,
  output logic        out_personal_improved,
  output logic        out_global_improved,
  output logic [47:0] out_best_score,
  output logic [31:0] out_best_pos_x,
  output logic [31:0] out_best_pos_y,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
  localparam int DEPTH2 = 2 * PARTICLE_COUNT;

  // state
  psue_pkg::state_t  state_r;
  psue_pkg::mul_op_t op_r;
  logic              d_r;
  logic [AW-1:0]     a_r;
  logic [4:0]        idx_r;
  logic              func_r;
  logic [31:0]       ld_x_r, ld_y_r;
  logic [15:0]       rc_x_r, rs_x_r, rp_x_r, rc_y_r, rs_y_r, rp_y_r;
  logic [15:0]       w_r, gc_r, gs_r, gp_r;
  logic signed [47:0] gbest_r;
  logic [31:0]       gb_x_r, gb_y_r;
  logic [31:0]       np_x_r, np_y_r;

  logic signed [51:0] mul_a_r, mul_acc_r;
  logic [17:0]        mul_b_r;
  logic [4:0]         cnt_r;
  logic [15:0]        g_r;
  logic signed [39:0] vacc_r;
  logic signed [35:0] sum_r;

  logic [47:0]        sq_n_r;
  logic [48:0]        sq_root_r, sq_bit_r;
  logic [25:0]        rem_r;
  logic signed [20:0] cz_r;
  logic signed [19:0] cx_r, cy_r;

  logic signed [47:0] fit_r;
  logic               pimp_r, gimp_r;

  logic               out_valid_r;
  logic [47:0]        out_fit_r, out_best_r;
  logic               out_pimp_r, out_gimp_r;
  logic [31:0]        out_bx_r, out_by_r;

  // memories
  logic [31:0] pos_mem [DEPTH2];
  logic [31:0] vel_mem [DEPTH2];
  logic [31:0] pb_mem  [DEPTH2];
  logic [47:0] pbf_mem [PARTICLE_COUNT];
  logic [31:0] pos_q, vel_q, pb_q;
  logic [47:0] pbf_q;

  logic          pos_we, vel_we, pb_we, pbf_we;
  logic [31:0]   pos_wd, vel_wd, pb_wd;
  logic [AW:0]   rd_addr, pb_waddr;

  // handshake
  logic in_acc, out_free;
  logic [31:0] idx_ext;
  logic in_range;

  assign in_stall  = (state_r != psue_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign idx_ext   = 32'(in_particle_index);
  assign in_range  = idx_ext < 32'(PARTICLE_COUNT);

  assign rd_addr   = {a_r, d_r};

  // per-dimension operand views
  logic [31:0] x_cur, np_cur, gb_cur;
  logic [15:0] rc_cur, rs_cur, rp_cur;
  logic signed [32:0] pdiff, gdiff;

  assign np_cur = d_r ? np_y_r : np_x_r;
  assign gb_cur = d_r ? gb_y_r : gb_x_r;
  assign rc_cur = d_r ? rc_y_r : rc_x_r;
  assign rs_cur = d_r ? rs_y_r : rs_x_r;
  assign rp_cur = d_r ? rp_y_r : rp_x_r;
  assign x_cur  = pos_q;
  assign pdiff  = $signed({pb_q[31], pb_q}) - $signed({x_cur[31], x_cur});
  assign gdiff  = $signed({gb_cur[31], gb_cur}) - $signed({x_cur[31], x_cur});

  // velocity and position update
  logic signed [39:0] vel_sum;
  logic [31:0]        vel_new, pos_new;
  logic signed [39:0] pos_sum;
  assign vel_sum = vacc_r;
  assign vel_new = psue_pkg::sat40(vel_sum);
  assign pos_sum = 40'($signed(x_cur)) + 40'($signed(vel_new));
  assign pos_new = psue_pkg::sat40(pos_sum);

  // root step
  logic [49:0] sq_t;
  logic        sq_ge;
  logic [48:0] sq_root_nxt;
  assign sq_t  = {1'b0, sq_root_r} + {1'b0, sq_bit_r};
  assign sq_ge = {2'b00, sq_n_r} >= sq_t;
  assign sq_root_nxt = sq_ge ? ((sq_root_r >> 1) + sq_bit_r) : (sq_root_r >> 1);

  // modulo step
  function automatic logic [25:0] TWO_PI_SHIFT(input logic [2:0] k);
    return psue_pkg::TWO_PI_Q << k;
  endfunction

  logic [25:0] mod_sub;
  assign mod_sub = TWO_PI_SHIFT(cnt_r[2:0]);

  // angle folding
  logic signed [20:0] fz0, fz1, fz2;
  always_comb begin
    fz0 = $signed({2'b00, rem_r[18:0]});
    fz1 = (fz0 > psue_pkg::PI_Q) ? (fz0 - psue_pkg::TWO_PI_S) : fz0;
    if (fz1 > psue_pkg::HALF_PI_Q) begin
      fz2 = psue_pkg::PI_Q - fz1;
    end else if (fz1 < -psue_pkg::HALF_PI_Q) begin
      fz2 = -psue_pkg::PI_Q - fz1;
    end else begin
      fz2 = fz1;
    end
  end

  // cordic rotation step
  logic signed [19:0] cdx, cdy;
  logic signed [20:0] catan;
  assign cdx   = cy_r >>> cnt_r;
  assign cdy   = cx_r >>> cnt_r;
  assign catan = $signed({4'b0000, psue_pkg::atan_q(cnt_r)});

  logic [19:0] cy_abs;
  assign cy_abs = cy_r[19] ? 20'(-cy_r) : 20'(cy_r);

  // multiplier operand selection
  logic signed [51:0] mld_a;
  logic [17:0]        mld_b;
  always_comb begin
    case (op_r)
      psue_pkg::OP_INERTIA: begin
        mld_a = 52'($signed(vel_q));
        mld_b = {2'b00, w_r};
      end
      psue_pkg::OP_COG_G: begin
        mld_a = 52'({16'h0000, gc_r});
        mld_b = {2'b00, rc_cur};
      end
      psue_pkg::OP_COG_T: begin
        mld_a = 52'(pdiff);
        mld_b = {2'b00, g_r};
      end
      psue_pkg::OP_SOC_G: begin
        mld_a = 52'({16'h0000, gs_r});
        mld_b = {2'b00, rs_cur};
      end
      psue_pkg::OP_SOC_T: begin
        mld_a = 52'(gdiff);
        mld_b = {2'b00, g_r};
      end
      psue_pkg::OP_PHI_G: begin
        mld_a = 52'({16'h0000, gp_r});
        mld_b = {2'b00, rp_cur};
      end
      psue_pkg::OP_PHI_T: begin
        mld_a = 52'(gdiff);
        mld_b = {2'b00, g_r};
      end
      default: begin
        mld_a = 52'($signed(np_cur));
        mld_b = cy_abs[17:0];
      end
    endcase
  end

  // fitness product sign and result
  logic signed [51:0] fit_prod;
  logic signed [35:0] fit_term;
  logic signed [39:0] vel_term;
  assign fit_prod = cy_r[19] ? -mul_acc_r : mul_acc_r;
  assign fit_term = fit_prod[51:16];
  assign vel_term = mul_acc_r[51:12];

  // final score compare
  logic signed [47:0] fit_new;
  logic               pimp_new, gimp_new;
  assign fit_new  = psue_pkg::FIT_BIAS2 - 48'(sum_r);
  assign pimp_new = !func_r || (fit_new < $signed(pbf_q));
  assign gimp_new = func_r ? (fit_new < gbest_r) : (idx_r == 5'd0);

  // memory write controls
  always_comb begin
    pos_we   = 1'b0;
    vel_we   = 1'b0;
    pb_we    = 1'b0;
    pbf_we   = 1'b0;
    pos_wd   = pos_new;
    vel_wd   = vel_new;
    pb_wd    = np_x_r;
    pb_waddr = {a_r, 1'b0};
    unique case (state_r)
      psue_pkg::S_LD: begin
        pos_we = 1'b1;
        vel_we = 1'b1;
        pos_wd = d_r ? ld_y_r : ld_x_r;
        vel_wd = 32'h0000_0000;
      end
      psue_pkg::S_VEL: begin
        pos_we = 1'b1;
        vel_we = 1'b1;
      end
      psue_pkg::S_FIN: begin
        pb_we  = pimp_new;
        pbf_we = pimp_new;
      end
      psue_pkg::S_PB: begin
        pb_we    = pimp_r;
        pb_wd    = np_y_r;
        pb_waddr = {a_r, 1'b1};
      end
      default: begin
      end
    endcase
  end

  // particle table memories
  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[rd_addr] <= pos_wd;
    pos_q <= pos_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (vel_we) vel_mem[rd_addr] <= vel_wd;
    vel_q <= vel_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pb_we) pb_mem[pb_waddr] <= pb_wd;
    pb_q <= pb_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pbf_we) pbf_mem[a_r] <= fit_new;
    pbf_q <= pbf_mem[a_r];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r  <= psue_pkg::INERTIA_RST;
      gc_r <= psue_pkg::COGNITIVE_RST;
      gs_r <= psue_pkg::SOCIAL_RST;
      gp_r <= psue_pkg::EXTRA_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        psue_pkg::CFG_INERTIA:   w_r  <= cfg_data;
        psue_pkg::CFG_COGNITIVE: gc_r <= cfg_data;
        psue_pkg::CFG_SOCIAL:    gs_r <= cfg_data;
        psue_pkg::CFG_EXTRA:     gp_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psue_pkg::S_IDLE;
      gbest_r <= psue_pkg::BEST_RST;
      gb_x_r  <= 32'h0000_0000;
      gb_y_r  <= 32'h0000_0000;
      op_r    <= psue_pkg::OP_INERTIA;
      d_r     <= 1'b0;
      cnt_r   <= 5'd0;
    end else begin
      unique case (state_r)
        psue_pkg::S_IDLE: begin
          if (in_acc) begin
            d_r    <= 1'b0;
            sum_r  <= '0;
            vacc_r <= '0;
            if (!in_range) begin
              fit_r   <= '0;
              pimp_r  <= 1'b0;
              gimp_r  <= 1'b0;
              state_r <= psue_pkg::S_OUT;
            end else if (!in_func) begin
              state_r <= psue_pkg::S_LD;
            end else begin
              state_r <= psue_pkg::S_RD;
            end
          end
        end
        psue_pkg::S_RD: begin
          op_r    <= psue_pkg::OP_INERTIA;
          vacc_r  <= '0;
          state_r <= psue_pkg::S_MLD;
        end
        psue_pkg::S_LD: begin
          if (d_r) begin
            np_y_r  <= ld_y_r;
            d_r     <= 1'b0;
            state_r <= psue_pkg::S_SQLD;
          end else begin
            np_x_r <= ld_x_r;
            d_r    <= 1'b1;
          end
        end
        psue_pkg::S_MLD: begin
          mul_a_r   <= mld_a;
          mul_b_r   <= mld_b;
          mul_acc_r <= '0;
          cnt_r     <= 5'd0;
          state_r   <= psue_pkg::S_MRUN;
        end
        psue_pkg::S_MRUN: begin
          if (mul_b_r[0]) mul_acc_r <= mul_acc_r + mul_a_r;
          mul_a_r <= mul_a_r <<< 1;
          mul_b_r <= mul_b_r >> 1;
          cnt_r   <= cnt_r + 5'd1;
          if (cnt_r == 5'(psue_pkg::MUL_BITS - 1)) state_r <= psue_pkg::S_MWB;
        end
        psue_pkg::S_MWB: begin
          case (op_r)
            psue_pkg::OP_FIT: begin
              sum_r <= sum_r + fit_term;
              if (d_r) begin
                state_r <= psue_pkg::S_FIN;
              end else begin
                d_r     <= 1'b1;
                state_r <= psue_pkg::S_SQLD;
              end
            end
            psue_pkg::OP_COG_G, psue_pkg::OP_SOC_G, psue_pkg::OP_PHI_G: begin
              g_r     <= mul_acc_r[31:16];
              op_r    <= psue_pkg::mul_op_t'(op_r + 3'd1);
              state_r <= psue_pkg::S_MLD;
            end
            psue_pkg::OP_PHI_T: begin
              vacc_r  <= vacc_r + vel_term;
              state_r <= psue_pkg::S_VEL;
            end
            default: begin
              vacc_r  <= vacc_r + vel_term;
              op_r    <= psue_pkg::mul_op_t'(op_r + 3'd1);
              state_r <= psue_pkg::S_MLD;
            end
          endcase
        end
        psue_pkg::S_VEL: begin
          if (d_r) begin
            np_y_r  <= pos_new;
            d_r     <= 1'b0;
            state_r <= psue_pkg::S_SQLD;
          end else begin
            np_x_r  <= pos_new;
            d_r     <= 1'b1;
            state_r <= psue_pkg::S_RD;
          end
        end
        psue_pkg::S_SQLD: begin
          sq_n_r    <= {(np_cur[31] ? 32'(-np_cur) : np_cur), 16'h0000};
          sq_root_r <= '0;
          sq_bit_r  <= 49'h1_0000_0000_0000;
          state_r   <= psue_pkg::S_SQ;
        end
        psue_pkg::S_SQ: begin
          if (sq_ge) sq_n_r <= sq_n_r - sq_t[47:0];
          sq_root_r <= sq_root_nxt;
          sq_bit_r  <= sq_bit_r >> 2;
          if (sq_bit_r[0]) begin
            rem_r   <= {1'b0, sq_root_nxt[24:0]};
            cnt_r   <= 5'd6;
            state_r <= psue_pkg::S_MOD;
          end
        end
        psue_pkg::S_MOD: begin
          if (rem_r >= mod_sub) rem_r <= rem_r - mod_sub;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) state_r <= psue_pkg::S_FOLD;
        end
        psue_pkg::S_FOLD: begin
          cz_r    <= fz2;
          cx_r    <= psue_pkg::CORDIC_K;
          cy_r    <= '0;
          cnt_r   <= 5'd0;
          state_r <= psue_pkg::S_COR;
        end
        psue_pkg::S_COR: begin
          if (!cz_r[20]) begin
            cx_r <= cx_r - cdx;
            cy_r <= cy_r + cdy;
            cz_r <= cz_r - catan;
          end else begin
            cx_r <= cx_r + cdx;
            cy_r <= cy_r - cdy;
            cz_r <= cz_r + catan;
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(psue_pkg::CORDIC_N - 1)) begin
            op_r    <= psue_pkg::OP_FIT;
            state_r <= psue_pkg::S_MLD;
          end
        end
        psue_pkg::S_FIN: begin
          fit_r  <= fit_new;
          pimp_r <= pimp_new;
          gimp_r <= gimp_new;
          if (gimp_new) begin
            gbest_r <= fit_new;
            gb_x_r  <= np_x_r;
            gb_y_r  <= np_y_r;
          end
          state_r <= psue_pkg::S_PB;
        end
        psue_pkg::S_PB: begin
          state_r <= psue_pkg::S_OUT;
        end
        psue_pkg::S_OUT: begin
          if (out_free) state_r <= psue_pkg::S_IDLE;
        end
        default: begin
          state_r <= psue_pkg::S_IDLE;
        end
      endcase
    end
  end

  // input transaction capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r  <= in_particle_index;
      a_r    <= idx_ext[AW-1:0];
      func_r <= in_func;
      ld_x_r <= in_load_pos_x;
      ld_y_r <= in_load_pos_y;
      rc_x_r <= in_rand_cog_x;
      rs_x_r <= in_rand_soc_x;
      rp_x_r <= in_rand_phi_x;
      rc_y_r <= in_rand_cog_y;
      rs_y_r <= in_rand_soc_y;
      rp_y_r <= in_rand_phi_y;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == psue_pkg::S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == psue_pkg::S_OUT && out_free) begin
      out_fit_r  <= fit_r;
      out_pimp_r <= pimp_r;
      out_gimp_r <= gimp_r;
      out_best_r <= gbest_r;
      out_bx_r   <= gb_x_r;
      out_by_r   <= gb_y_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_particle_fitness  = out_fit_r;
  assign out_personal_improved = out_pimp_r;
  assign out_global_improved   = out_gimp_r;
  assign out_best_score        = out_best_r;
  assign out_best_pos_x        = out_bx_r;
  assign out_best_pos_y        = out_by_r;

endmodule

>>> tb/psue_result_checker.sv
// result checker for the particle swarm update engine: watches the in, cfg and out
// channels, predicts each result and compares it field by field; needs psue_pkg only
`timescale 1ns / 100ps

module psue_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_func,
  input  logic [4:0]  in_particle_index,
  input  logic [31:0] in_load_pos_x,
  input  logic [31:0] in_load_pos_y,
  input  logic [15:0] in_rand_cog_x,
  input  logic [15:0] in_rand_soc_x,
  input  logic [15:0] in_rand_phi_x,
  input  logic [15:0] in_rand_cog_y,
  input  logic [15:0] in_rand_soc_y,
  input  logic [15:0] in_rand_phi_y,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [47:0] out_particle_fitness,
  input  logic        out_personal_improved,
  input  logic        out_global_improved,
  input  logic [47:0] out_best_score,
  input  logic [31:0] out_best_pos_x,
  input  logic [31:0] out_best_pos_y,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [47:0] fitness;
    logic        pimp;
    logic        gimp;
    logic [47:0] best;
    logic [31:0] bx;
    logic [31:0] by;
  } swarm_result_t;

  swarm_result_t score_q[$];

  // shadow copy of the particle table and gains
  logic [15:0] w_inertia, w_cog, w_soc, w_phi;
  logic signed [31:0] pos_tab [32][2];
  logic signed [31:0] vel_tab [32][2];
  logic signed [31:0] pb_tab  [32][2];
  logic signed [63:0] pbfit_tab [32];
  logic signed [63:0] gbest;
  logic signed [31:0] gpos [2];

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint floor_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 48;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint cordic_sine(longint a);
    longint r, x, y, dx, dy;
    r = a % 411775;
    x = 39797;
    y = 0;
    if (r > 205887) r -= 411775;
    if (r > 102944) r = 205887 - r;
    else if (r < -102944) r = -205887 - r;
    for (int i = 0; i < 24; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (r >= 0) begin
        x -= dx; y += dy; r -= longint'(psue_pkg::atan_q(5'(i)));
      end else begin
        x += dx; y -= dy; r += longint'(psue_pkg::atan_q(5'(i)));
      end
    end
    return y;
  endfunction

  function automatic longint schwefel_score(logic signed [31:0] px, logic signed [31:0] py);
    longint sum, x, ax;
    sum = 0;
    for (int d = 0; d < 2; d++) begin
      x = (d == 0) ? longint'(px) : longint'(py);
      ax = x < 0 ? -x : x;
      sum += asr(x * cordic_sine(floor_root(longint'(ax) << 16)), 16);
    end
    return 64'sd54916926 - sum;
  endfunction

  function automatic longint gain_pull(logic [15:0] g, logic [15:0] rnd, longint diff);
    longint gg;
    gg = (longint'(g) * longint'(rnd)) >> 16;
    return asr(gg * diff, 12);
  endfunction

  // advance the shadow table by one accepted transaction
  task automatic predict_step(input logic fn, input logic [4:0] idx,
                              input logic [31:0] lx, input logic [31:0] ly,
                              input logic [15:0] rnd [6]);
    swarm_result_t e;
    longint fit, nv, x, gd;
    e = '0;
    if (fn == 1'b0) begin
      pos_tab[idx][0] = lx;
      pos_tab[idx][1] = ly;
      for (int d = 0; d < 2; d++) begin
        vel_tab[idx][d] = 0;
        pb_tab[idx][d] = pos_tab[idx][d];
      end
      fit = schwefel_score(pos_tab[idx][0], pos_tab[idx][1]);
      pbfit_tab[idx] = fit;
      e.pimp = 1'b1;
      if (idx == 0) begin
        gbest = fit;
        gpos[0] = pos_tab[0][0];
        gpos[1] = pos_tab[0][1];
        e.gimp = 1'b1;
      end
    end else begin
      for (int d = 0; d < 2; d++) begin
        x = pos_tab[idx][d];
        gd = longint'(gpos[d]) - x;
        nv = asr(longint'(w_inertia) * longint'(vel_tab[idx][d]), 12)
           + gain_pull(w_cog, rnd[3*d], longint'(pb_tab[idx][d]) - x)
           + gain_pull(w_soc, rnd[3*d+1], gd)
           + gain_pull(w_phi, rnd[3*d+2], gd);
        vel_tab[idx][d] = clamp32(nv);
      end
      for (int d = 0; d < 2; d++)
        pos_tab[idx][d] = clamp32(longint'(pos_tab[idx][d]) + longint'(vel_tab[idx][d]));
      fit = schwefel_score(pos_tab[idx][0], pos_tab[idx][1]);
      if (fit < pbfit_tab[idx]) begin
        pbfit_tab[idx] = fit;
        pb_tab[idx] = pos_tab[idx];
        e.pimp = 1'b1;
      end
      if (fit < gbest) begin
        gbest = fit;
        gpos = pos_tab[idx];
        e.gimp = 1'b1;
      end
    end
    e.fitness = fit[47:0];
    e.best = gbest[47:0];
    e.bx = gpos[0];
    e.by = gpos[1];
    score_q.push_back(e);
  endtask

  assign pending_count = score_q.size();

  always @(posedge clk) begin
    logic [15:0] rnd [6];
    swarm_result_t exp_r, got;
    if (!rst_n) begin
      w_inertia = psue_pkg::INERTIA_RST;
      w_cog = psue_pkg::COGNITIVE_RST;
      w_soc = psue_pkg::SOCIAL_RST;
      w_phi = psue_pkg::EXTRA_RST;
      gbest = 64'sd140737488355327;
      gpos[0] = 0;
      gpos[1] = 0;
      for (int i = 0; i < 32; i++) begin
        pbfit_tab[i] = 0;
        for (int d = 0; d < 2; d++) begin
          pos_tab[i][d] = 0; vel_tab[i][d] = 0; pb_tab[i][d] = 0;
        end
      end
      score_q.delete();
      fail_count = 0;
    end else begin
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          psue_pkg::CFG_INERTIA:   w_inertia = cfg_data;
          psue_pkg::CFG_COGNITIVE: w_cog = cfg_data;
          psue_pkg::CFG_SOCIAL:    w_soc = cfg_data;
          psue_pkg::CFG_EXTRA:     w_phi = cfg_data;
        endcase
      end
      // result transaction
      if (out_valid && !out_stall) begin
        got = {out_particle_fitness, out_personal_improved, out_global_improved,
               out_best_score, out_best_pos_x, out_best_pos_y};
        if (score_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, got);
          fail_count++;
        end else begin
          exp_r = score_q.pop_front();
          if (got.fitness !== exp_r.fitness) begin
            $display("%0t: particle_fitness expected %h actual %h",
                     $time, exp_r.fitness, got.fitness);
            fail_count++;
          end
          if (got.pimp !== exp_r.pimp) begin
            $display("%0t: personal_improved expected %b actual %b",
                     $time, exp_r.pimp, got.pimp);
            fail_count++;
          end
          if (got.gimp !== exp_r.gimp) begin
            $display("%0t: global_improved expected %b actual %b",
                     $time, exp_r.gimp, got.gimp);
            fail_count++;
          end
          if (got.best !== exp_r.best) begin
            $display("%0t: best_score expected %h actual %h", $time, exp_r.best, got.best);
            fail_count++;
          end
          if (got.bx !== exp_r.bx) begin
            $display("%0t: best_pos_x expected %h actual %h", $time, exp_r.bx, got.bx);
            fail_count++;
          end
          if (got.by !== exp_r.by) begin
            $display("%0t: best_pos_y expected %h actual %h", $time, exp_r.by, got.by);
            fail_count++;
          end
        end
      end
      // input transaction, predicted after the result pop so ordering holds
      if (in_valid && !in_stall) begin
        rnd[0] = in_rand_cog_x; rnd[1] = in_rand_soc_x; rnd[2] = in_rand_phi_x;
        rnd[3] = in_rand_cog_y; rnd[4] = in_rand_soc_y; rnd[5] = in_rand_phi_y;
        predict_step(in_func, in_particle_index, in_load_pos_x, in_load_pos_y, rnd);
      end
    end
  end

endmodule

>>> tb/tb_particle_swarm_update_engine_core.sv
// stimulus and verdict for particle_swarm_update_engine_core
// depends on psue_pkg, the core and psue_result_checker
`timescale 1ns / 100ps

module tb_particle_swarm_update_engine_core;

  localparam int RANDOM_ITEMS = 1500;
  localparam int IDLE_LIMIT   = 20000;

  logic        clk, rst_n;
  logic        in_valid, in_stall, in_func;
  logic [4:0]  in_particle_index;
  logic [31:0] in_load_pos_x, in_load_pos_y;
  logic [15:0] in_rand_cog_x, in_rand_soc_x, in_rand_phi_x;
  logic [15:0] in_rand_cog_y, in_rand_soc_y, in_rand_phi_y;
  logic        out_valid, out_stall;
  logic [47:0] out_particle_fitness, out_best_score;
  logic        out_personal_improved, out_global_improved;
  logic [31:0] out_best_pos_x, out_best_pos_y;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count, pending_count;
  int          idle_cycles;
  bit          sink_hold, sink_quiet;
  bit          loaded [32];

  particle_swarm_update_engine_core uut (.*);
  psue_result_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on accepted transactions
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (sink_hold) out_stall <= 1'b1;
    else if (sink_quiet) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 13);
  end

  task automatic send_item(input logic fn, input logic [4:0] idx,
                           input logic [31:0] lx, input logic [31:0] ly, input bit gaps);
    while (gaps && $urandom_range(99) < 13) @(negedge clk);
    in_valid = 1'b1;
    in_func = fn;
    in_particle_index = idx;
    in_load_pos_x = lx;
    in_load_pos_y = ly;
    in_rand_cog_x = 16'($urandom); in_rand_soc_x = 16'($urandom);
    in_rand_phi_x = 16'($urandom);
    in_rand_cog_y = 16'($urandom); in_rand_soc_y = 16'($urandom);
    in_rand_phi_y = 16'($urandom);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    if (fn == 1'b0) loaded[idx] = 1'b1;
  endtask

  task automatic drain_results();
    while (pending_count != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_gain(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // start positions: mostly in the usual search range, sometimes extremes
  function automatic logic [31:0] pick_pos();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(1000 << 16)) - (500 << 16));
    endcase
  endfunction

  function automatic logic [4:0] pick_loaded();
    logic [4:0] i;
    do i = 5'($urandom_range(31)); while (!loaded[i]);
    return i;
  endfunction

  task automatic run_phase(input int n, input bit gaps);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) < 2 || !loaded[0])
        send_item(1'b0, loaded[0] ? 5'($urandom_range(31)) : 5'd0,
                  pick_pos(), pick_pos(), gaps);
      else
        send_item(1'b1, pick_loaded(), $urandom, $urandom, gaps);
    end
  endtask

  initial begin
    in_valid = 0; in_func = 0; in_particle_index = 0;
    in_load_pos_x = 0; in_load_pos_y = 0;
    in_rand_cog_x = 0; in_rand_soc_x = 0; in_rand_phi_x = 0;
    in_rand_cog_y = 0; in_rand_soc_y = 0; in_rand_phi_y = 0;
    cfg_valid = 0; cfg_index = psue_pkg::CFG_INERTIA; cfg_data = 0;
    sink_hold = 0; sink_quiet = 0;
    rst_n = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: extremes, zero, particles 0 to 4, 31 and every third from 4 loaded, update edges
    send_item(1'b0, 5'd0, 32'h0000_0000, 32'h0000_0000, 0);
    send_item(1'b0, 5'd31, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_item(1'b0, 5'd1, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_item(1'b0, 5'd2, 32'hFFFF_FFFF, 32'h0000_0001, 0);
    send_item(1'b0, 5'd3, 32'd27_525_120, 32'hFE5C_0000, 0);
    for (int i = 4; i < 31; i += 3)
      send_item(1'b0, 5'(i), pick_pos(), pick_pos(), 0);
    for (int i = 0; i < 32; i++)
      if (!loaded[i]) loaded[i] = 1'b0;
    send_item(1'b1, 5'd31, 0, 0, 0);
    send_item(1'b1, 5'd1, 0, 0, 0);
    send_item(1'b1, 5'd2, 0, 0, 0);
    send_item(1'b1, 5'd0, 0, 0, 0);
    drain_results();

    // gain extremes, each register written
    write_gain(psue_pkg::CFG_INERTIA, 16'hFFFF);
    write_gain(psue_pkg::CFG_COGNITIVE, 16'hFFFF);
    write_gain(psue_pkg::CFG_SOCIAL, 16'hFFFF);
    write_gain(psue_pkg::CFG_EXTRA, 16'hFFFF);
    run_phase(20, 1);
    drain_results();
    write_gain(psue_pkg::CFG_INERTIA, 16'h0000);
    write_gain(psue_pkg::CFG_COGNITIVE, 16'h0000);
    write_gain(psue_pkg::CFG_SOCIAL, 16'h0000);
    write_gain(psue_pkg::CFG_EXTRA, 16'h0000);
    run_phase(20, 1);
    drain_results();

    // typical gains, then random ones
    write_gain(psue_pkg::CFG_INERTIA, 16'd2900);
    write_gain(psue_pkg::CFG_COGNITIVE, 16'd6000);
    write_gain(psue_pkg::CFG_SOCIAL, 16'd6000);
    write_gain(psue_pkg::CFG_EXTRA, 16'd1024);
    run_phase(500, 1);

    // long receiver hold while the sender keeps offering
    fork
      begin
        sink_hold = 1;
        repeat (3000) @(negedge clk);
        sink_hold = 0;
      end
      run_phase(20, 0);
    join
    drain_results();

    for (int p = 0; p < 3; p++) begin
      write_gain(psue_pkg::CFG_INERTIA, 16'($urandom));
      write_gain(psue_pkg::CFG_COGNITIVE, 16'($urandom_range(12000)));
      write_gain(psue_pkg::CFG_SOCIAL, 16'($urandom_range(12000)));
      write_gain(psue_pkg::CFG_EXTRA, 16'($urandom_range(4096)));
      run_phase(200, 1);
      drain_results();
    end

    // stretch with no idling on either side
    sink_quiet = 1;
    run_phase(340, 0);
    sink_quiet = 0;
    drain_results();

    if (fail_count == 0 && pending_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
